// ===== rtl/core/lbc_pkg.sv =====
// Shared types, constants and helpers of the line-buffered 2D convolution block.
// Depends on nothing; lbc_front, lbc_back and the top module refer to it by scoped names.
package lbc_pkg;

    // Default build sizes.
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_KERNEL_H     = 3;
    localparam int DEF_KERNEL_W     = 3;
    localparam int DEF_IN_CH        = 3;
    localparam int DEF_OUT_CH       = 4;
    localparam int DEF_SAMPLE_BITS  = 8;
    localparam int DEF_QUEUE_DEPTH  = 8;

    // Fixed field widths of the stream words.
    localparam int WIDX_BITS  = 7;
    localparam int WVAL_BITS  = 8;
    localparam int PFIELD_BITS = 8;
    localparam int MAX_IN_CH  = 3;
    localparam int MAX_OUT_CH = 4;
    localparam int ROW_BITS   = 12;
    localparam int OCOL_BITS  = 10;
    localparam int SUM_BITS   = 32;
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 152;

    // Input word field offsets.
    localparam int WIDX_LSB = 0;
    localparam int WVAL_LSB = WIDX_LSB + WIDX_BITS;
    localparam int PIX_LSB  = WVAL_LSB + WVAL_BITS;

    // Configuration register fields.
    localparam int IMG_W_BITS  = 11;
    localparam int IMG_H_BITS  = 13;
    localparam int STRIDE_BITS = 3;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam logic [IMG_W_BITS-1:0]  IMG_W_RESET  = 11'd1024;
    localparam logic [IMG_H_BITS-1:0]  IMG_H_RESET  = 13'd1024;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 3'd1;
    localparam logic [IMG_H_BITS-1:0]  MAX_HEIGHT   = 13'd4096;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_IMG_W  = 2'd0,
        CFG_IMG_H  = 2'd1,
        CFG_STRIDE = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        CMD_WEIGHT = 1'b0,
        CMD_PIXEL  = 1'b1
    } t_cmd;

    // Status of the back half as the front sees it.
    typedef struct packed {
        logic back_busy;
        logic queue_empty;
    } t_pipe_status;

    // Divide a position by a stride of 1 to 4; a third is a reciprocal multiply.
    function automatic logic [ROW_BITS-1:0] div_stride(input logic [ROW_BITS-1:0] x,
                                                       input logic [STRIDE_BITS-1:0] s);
        logic [28:0] prod;
        logic [ROW_BITS-1:0] q;
        begin
            prod = 29'(x) * 29'(17'd43691);
            case (s)
                3'd2:    q = x >> 1;
                3'd3:    q = prod[28:17];
                3'd4:    q = x >> 2;
                default: q = x;
            endcase
            return q;
        end
    endfunction

endpackage

// ===== rtl/core/lbc_fifo.sv =====
// Short word queue between the front and the back of the convolution block.
// Depends on nothing but its parameters.
module lbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_din,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_dout,
    output logic                       o_valid,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_count, n_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_dout  = r_mem[r_rptr];
    assign o_count = r_count;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end
endmodule

// ===== rtl/core/lbc_front.sv =====
// Front half: accepts words, keeps weights, counters and line buffer, builds windows.
// Depends on lbc_pkg.
module lbc_front #(
    parameter int MAX_WIDTH    = lbc_pkg::DEF_MAX_WIDTH,
    parameter int KERNEL_H     = lbc_pkg::DEF_KERNEL_H,
    parameter int KERNEL_W     = lbc_pkg::DEF_KERNEL_W,
    parameter int IN_CH        = lbc_pkg::DEF_IN_CH,
    parameter int OUT_CH       = lbc_pkg::DEF_OUT_CH,
    parameter int SAMPLE_BITS  = lbc_pkg::DEF_SAMPLE_BITS,
    parameter int QUEUE_DEPTH  = lbc_pkg::DEF_QUEUE_DEPTH,
    localparam int NUM_W       = OUT_CH * IN_CH * KERNEL_H * KERNEL_W,
    localparam int WIN_BITS    = KERNEL_H * KERNEL_W * IN_CH * SAMPLE_BITS,
    localparam int ITEM_BITS   = lbc_pkg::ROW_BITS + lbc_pkg::OCOL_BITS + WIN_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [lbc_pkg::IN_TDATA_BITS-1:0]      i_s_tdata,
    input  logic                                   i_s_tuser,
    input  logic                                   i_cfg_valid,
    input  logic [lbc_pkg::CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [lbc_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic [$clog2(QUEUE_DEPTH):0]           i_queue_count,
    input  lbc_pkg::t_pipe_status                  i_status,
    output logic                                   o_push,
    output logic [ITEM_BITS-1:0]                   o_item,
    output logic [NUM_W*lbc_pkg::WVAL_BITS-1:0]    o_weights
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int BW = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
    localparam int PW = IN_CH * SAMPLE_BITS;
    localparam int RB = lbc_pkg::ROW_BITS;
    localparam int HB = lbc_pkg::IMG_H_BITS;
    localparam int PFIELD_PAD = 24;

    // Configuration registers.
    logic [lbc_pkg::IMG_W_BITS-1:0]  r_img_w;
    logic [lbc_pkg::IMG_H_BITS-1:0]  r_img_h;
    logic [lbc_pkg::STRIDE_BITS-1:0] r_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= lbc_pkg::IMG_W_RESET;
            r_img_h  <= lbc_pkg::IMG_H_RESET;
            r_stride <= lbc_pkg::STRIDE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                lbc_pkg::CFG_IMG_W:  r_img_w  <= i_cfg_data[lbc_pkg::IMG_W_BITS-1:0];
                lbc_pkg::CFG_IMG_H:  r_img_h  <= i_cfg_data[lbc_pkg::IMG_H_BITS-1:0];
                lbc_pkg::CFG_STRIDE: r_stride <= i_cfg_data[lbc_pkg::STRIDE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Registers saturated to their working ranges.
    logic [HB-1:0] w_ext, w_lim, h_lim;
    logic [lbc_pkg::STRIDE_BITS-1:0] s_lim;

    always_comb begin
        w_ext = HB'(r_img_w);
        if (w_ext < HB'(3)) begin
            w_lim = HB'(3);
        end else if (w_ext > HB'(MAX_WIDTH)) begin
            w_lim = HB'(MAX_WIDTH);
        end else begin
            w_lim = w_ext;
        end
        if (r_img_h < HB'(3)) begin
            h_lim = HB'(3);
        end else if (r_img_h > lbc_pkg::MAX_HEIGHT) begin
            h_lim = lbc_pkg::MAX_HEIGHT;
        end else begin
            h_lim = r_img_h;
        end
        if (r_stride == '0) begin
            s_lim = 3'd1;
        end else if (r_stride > 3'd4) begin
            s_lim = 3'd4;
        end else begin
            s_lim = r_stride;
        end
    end

    // Registers of the stage after the line buffer read.
    logic                         r_s0_valid;
    logic                         r_s0_emit;
    logic [RB-1:0]                r_s0_row;
    logic [lbc_pkg::OCOL_BITS-1:0] r_s0_col;
    logic [BW-1:0]                r_s0_bank;
    logic [PW-1:0]                r_s0_pix;
    logic [RB-1:0]                ocol_full;

    // Input handshake: pixels need queue room, weight writes need an empty pipe.
    logic is_pixel, px_acc, wt_acc;
    assign is_pixel = (i_s_tuser == lbc_pkg::CMD_PIXEL);
    always_comb begin
        if (is_pixel) begin
            o_s_tready = (i_queue_count <= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH - 3));
        end else begin
            o_s_tready = !r_s0_valid && i_status.queue_empty && !i_status.back_busy;
        end
    end
    assign px_acc = i_s_tvalid && o_s_tready && is_pixel;
    assign wt_acc = i_s_tvalid && o_s_tready && !is_pixel;

    // Weight store, one register per tap so each multiplier has its own.
    logic [lbc_pkg::WIDX_BITS-1:0] widx;
    logic [lbc_pkg::WVAL_BITS-1:0] r_weight [NUM_W];
    assign widx = i_s_tdata[lbc_pkg::WIDX_LSB +: lbc_pkg::WIDX_BITS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_W; i++) begin
            if (wt_acc && (32'(widx) == i)) begin
                r_weight[i] <= i_s_tdata[lbc_pkg::WVAL_LSB +: lbc_pkg::WVAL_BITS];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_W; i++) begin
            o_weights[i*lbc_pkg::WVAL_BITS +: lbc_pkg::WVAL_BITS] = r_weight[i];
        end
    end

    // Pixel samples cut to the sample width.
    logic [PW-1:0] pix;
    always_comb begin
        logic [PFIELD_PAD-1:0] wide;
        for (int c = 0; c < IN_CH; c++) begin
            wide = PFIELD_PAD'(i_s_tdata[lbc_pkg::PIX_LSB + c*lbc_pkg::PFIELD_BITS +:
                                         lbc_pkg::PFIELD_BITS]);
            pix[c*SAMPLE_BITS +: SAMPLE_BITS] = wide[SAMPLE_BITS-1:0];
        end
    end

    // Position counters and stride phases.
    logic [CW-1:0]  r_col, n_col;
    logic [RB-1:0]  r_row, n_row;
    logic [1:0]     r_cph, n_cph, r_rph, n_rph;
    logic [BW-1:0]  r_bank, n_bank;
    logic           emit_now;
    logic [RB-1:0]  r0, c0;

    assign emit_now = (r_row >= RB'(KERNEL_H - 1)) && (HB'(r_col) >= HB'(KERNEL_W - 1)) &&
                      (r_rph == '0) && (r_cph == '0);
    assign r0 = r_row - RB'(KERNEL_H - 1);
    assign c0 = RB'(r_col) - RB'(KERNEL_W - 1);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_cph  = r_cph;
        n_rph  = r_rph;
        n_bank = r_bank;
        if (HB'(r_col) >= w_lim - 1'b1) begin
            n_col = '0;
            n_cph = '0;
            if (HB'(r_row) >= h_lim - 1'b1) begin
                n_row  = '0;
                n_rph  = '0;
                n_bank = '0;
            end else begin
                if (r_row < RB'(KERNEL_H - 1) || (3'(r_rph) + 3'd1 >= s_lim)) begin
                    n_rph = '0;
                end else begin
                    n_rph = r_rph + 1'b1;
                end
                n_row  = r_row + 1'b1;
                n_bank = (r_bank == BW'(KERNEL_H - 1)) ? '0 : r_bank + 1'b1;
            end
        end else begin
            if (HB'(r_col) < HB'(KERNEL_W - 1) || (3'(r_cph) + 3'd1 >= s_lim)) begin
                n_cph = '0;
            end else begin
                n_cph = r_cph + 1'b1;
            end
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cph  <= '0;
            r_rph  <= '0;
            r_bank <= '0;
        end else if (px_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_cph  <= n_cph;
            r_rph  <= n_rph;
            r_bank <= n_bank;
        end
    end

    // Line buffer: one memory per row bank, all read at the current column.
    logic [PW-1:0] r_rd [KERNEL_H];

    for (genvar k = 0; k < KERNEL_H; k++) begin : g_bank
        logic [PW-1:0] r_line [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (px_acc && (r_bank == BW'(k))) begin
                r_line[r_col] <= pix;
            end
            if (px_acc) begin
                r_rd[k] <= r_line[r_col];
            end
        end
    end

    // Stage after the line buffer read.
    assign ocol_full = lbc_pkg::div_stride(c0, s_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= px_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (px_acc) begin
            r_s0_emit <= emit_now;
            r_s0_row  <= lbc_pkg::div_stride(r0, s_lim);
            r_s0_col  <= ocol_full[lbc_pkg::OCOL_BITS-1:0];
            r_s0_bank <= r_bank;
            r_s0_pix  <= pix;
        end
    end

    // Column of the window in row order, oldest row first.
    logic [KERNEL_H*PW-1:0] colv;
    always_comb begin
        logic [BW:0] bsum;
        logic [BW-1:0] bidx;
        for (int kr = 0; kr < KERNEL_H; kr++) begin
            bsum = (BW+1)'(r_s0_bank) + (BW+1)'(kr + 1);
            if (bsum >= (BW+1)'(KERNEL_H)) begin
                bsum = bsum - (BW+1)'(KERNEL_H);
            end
            bidx = bsum[BW-1:0];
            if (bidx == r_s0_bank) begin
                colv[kr*PW +: PW] = r_s0_pix;
            end else begin
                colv[kr*PW +: PW] = r_rd[bidx];
            end
        end
    end

    // Window of the last KERNEL_W columns.
    logic [KERNEL_H*PW-1:0] r_win [KERNEL_W];
    logic [KERNEL_H*PW-1:0] n_win [KERNEL_W];

    always_comb begin
        for (int kc = 0; kc < KERNEL_W - 1; kc++) begin
            n_win[kc] = r_win[kc + 1];
        end
        n_win[KERNEL_W-1] = colv;
    end

    always_ff @(posedge i_clk) begin
        if (r_s0_valid) begin
            for (int kc = 0; kc < KERNEL_W; kc++) begin
                r_win[kc] <= n_win[kc];
            end
        end
    end

    // Hand a complete window to the queue.
    logic [WIN_BITS-1:0] win_flat;
    always_comb begin
        for (int kr = 0; kr < KERNEL_H; kr++) begin
            for (int kc = 0; kc < KERNEL_W; kc++) begin
                for (int c = 0; c < IN_CH; c++) begin
                    win_flat[((kr*KERNEL_W + kc)*IN_CH + c)*SAMPLE_BITS +: SAMPLE_BITS] =
                        n_win[kc][kr*PW + c*SAMPLE_BITS +: SAMPLE_BITS];
                end
            end
        end
    end

    assign o_push = r_s0_valid && r_s0_emit;
    assign o_item = {win_flat, r_s0_col, r_s0_row};
endmodule

// ===== rtl/core/lbc_back.sv =====
// Back half: multiplies a window by the weights and sums per output channel.
// Depends on lbc_pkg.
module lbc_back #(
    parameter int KERNEL_H     = lbc_pkg::DEF_KERNEL_H,
    parameter int KERNEL_W     = lbc_pkg::DEF_KERNEL_W,
    parameter int IN_CH        = lbc_pkg::DEF_IN_CH,
    parameter int OUT_CH       = lbc_pkg::DEF_OUT_CH,
    parameter int SAMPLE_BITS  = lbc_pkg::DEF_SAMPLE_BITS,
    localparam int NUM_W       = OUT_CH * IN_CH * KERNEL_H * KERNEL_W,
    localparam int WIN_BITS    = KERNEL_H * KERNEL_W * IN_CH * SAMPLE_BITS,
    localparam int ITEM_BITS   = lbc_pkg::ROW_BITS + lbc_pkg::OCOL_BITS + WIN_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [ITEM_BITS-1:0]                   i_item,
    output logic                                   o_pop,
    input  logic [NUM_W*lbc_pkg::WVAL_BITS-1:0]    i_weights,
    output logic                                   o_busy,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [lbc_pkg::OUT_TDATA_BITS-1:0]     o_m_tdata
);
    localparam int RB   = lbc_pkg::ROW_BITS;
    localparam int OB   = lbc_pkg::OCOL_BITS;
    localparam int SB   = lbc_pkg::SUM_BITS;
    localparam int TAPS = KERNEL_H * KERNEL_W;
    localparam int PB   = SAMPLE_BITS + lbc_pkg::WVAL_BITS;

    logic r_a_valid, r_b_valid, r_c_valid;
    logic rdy_a, rdy_b, rdy_c;

    // Each stage moves when the one after it has room.
    assign rdy_c  = !r_c_valid || i_m_tready;
    assign rdy_b  = !r_b_valid || rdy_c;
    assign rdy_a  = !r_a_valid || rdy_b;
    assign o_pop  = i_valid && rdy_a;
    assign o_busy = r_a_valid || r_b_valid || r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) r_a_valid <= i_valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
        end
    end

    // Products, one multiplier per weight.
    logic signed [PB-1:0] r_prod [NUM_W];
    logic [RB-1:0] r_a_row, r_b_row, r_c_row;
    logic [OB-1:0] r_a_col, r_b_col, r_c_col;

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_row <= i_item[RB-1:0];
            r_a_col <= i_item[RB +: OB];
            for (int oc = 0; oc < OUT_CH; oc++) begin
                for (int c = 0; c < IN_CH; c++) begin
                    for (int t = 0; t < TAPS; t++) begin
                        r_prod[(oc*IN_CH + c)*TAPS + t] <=
                            PB'(signed'(i_item[RB + OB + (t*IN_CH + c)*SAMPLE_BITS +:
                                               SAMPLE_BITS]))
                          * PB'(signed'(i_weights[((oc*IN_CH + c)*TAPS + t)*
                                               lbc_pkg::WVAL_BITS +: lbc_pkg::WVAL_BITS]));
                    end
                end
            end
        end
    end

    // Partial sums per output and input channel.
    logic signed [SB-1:0] r_psum [OUT_CH*IN_CH];
    always_ff @(posedge i_clk) begin
        logic signed [SB-1:0] acc;
        if (rdy_b && r_a_valid) begin
            r_b_row <= r_a_row;
            r_b_col <= r_a_col;
            for (int g = 0; g < OUT_CH*IN_CH; g++) begin
                acc = '0;
                for (int t = 0; t < TAPS; t++) begin
                    acc = acc + SB'(r_prod[g*TAPS + t]);
                end
                r_psum[g] <= acc;
            end
        end
    end

    // Final sums form the output register.
    logic signed [SB-1:0] r_sum [lbc_pkg::MAX_OUT_CH];
    always_ff @(posedge i_clk) begin
        logic signed [SB-1:0] acc;
        if (rdy_c && r_b_valid) begin
            r_c_row <= r_b_row;
            r_c_col <= r_b_col;
            for (int oc = 0; oc < lbc_pkg::MAX_OUT_CH; oc++) begin
                acc = '0;
                if (oc < OUT_CH) begin
                    for (int c = 0; c < IN_CH; c++) begin
                        acc = acc + r_psum[oc*IN_CH + c];
                    end
                end
                r_sum[oc] <= acc;
            end
        end
    end

    assign o_m_tvalid = r_c_valid;
    assign o_m_tdata  = {2'b00, r_sum[3], r_sum[2], r_sum[1], r_sum[0], r_c_col, r_c_row};
endmodule

// ===== rtl/core/line_buffered_conv2d.sv =====
// Streaming multichannel 2D convolution with a line buffer, valid padding.
// Slave stream (i_s_*): tuser selects a weight write or a pixel; pixels come in raster
// order, one word per pixel, and are taken one per cycle while the queue has room.
// Master stream (o_m_*): one word per window that fits and lies on the stride grid.
// Configuration channel (i_cfg_*): image width, image height and stride, written while
// the block is idle; it is always ready.
// A pixel that completes a window passes five register stages (line buffer read with
// window shift, queue, product stage, two adder stages) before its result word is valid.
// Pixels are taken one per cycle while the queue has room, set by the single-port line
// buffer banks and the fully parallel multiplier array. A weight write waits until no
// result is in flight.
// Reset clears counters, phases and all pipeline valid flags; registers return to
// width 1024, height 1024, stride 1. Weights and line buffer hold no reset value.
// When the receiver stalls, results gather in an 8-word queue; pixels stall while the
// queue holds more than 5 words, leaving room for the pixels already on their way.
// Depends on lbc_pkg, lbc_front, lbc_fifo and lbc_back.
module line_buffered_conv2d #(
    parameter int MAX_WIDTH    = lbc_pkg::DEF_MAX_WIDTH,
    parameter int KERNEL_H     = lbc_pkg::DEF_KERNEL_H,
    parameter int KERNEL_W     = lbc_pkg::DEF_KERNEL_W,
    parameter int IN_CH        = lbc_pkg::DEF_IN_CH,
    parameter int OUT_CH       = lbc_pkg::DEF_OUT_CH,
    parameter int SAMPLE_BITS  = lbc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // weight_index, weight_value, pixel_ch0, pixel_ch1, pixel_ch2, one zero pad bit
    input  logic [lbc_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    // command
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_row, out_col, sum_ch0, sum_ch1, sum_ch2, sum_ch3, two zero pad bits
    output logic [lbc_pkg::OUT_TDATA_BITS-1:0] o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lbc_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [lbc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    localparam int QD        = lbc_pkg::DEF_QUEUE_DEPTH;
    localparam int NUM_W     = OUT_CH * IN_CH * KERNEL_H * KERNEL_W;
    localparam int WIN_BITS  = KERNEL_H * KERNEL_W * IN_CH * SAMPLE_BITS;
    localparam int ITEM_BITS = lbc_pkg::ROW_BITS + lbc_pkg::OCOL_BITS + WIN_BITS;

    logic                                 push, pop, q_valid, back_busy;
    logic [ITEM_BITS-1:0]                 push_item, q_item;
    logic [$clog2(QD):0]                  q_count;
    logic [NUM_W*lbc_pkg::WVAL_BITS-1:0]  weights;
    lbc_pkg::t_pipe_status                status;

    assign o_cfg_ready        = 1'b1;
    assign status.back_busy   = back_busy;
    assign status.queue_empty = !q_valid;

    lbc_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .KERNEL_H    (KERNEL_H),
        .KERNEL_W    (KERNEL_W),
        .IN_CH       (IN_CH),
        .OUT_CH      (OUT_CH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .QUEUE_DEPTH (QD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_queue_count (q_count),
        .i_status      (status),
        .o_push        (push),
        .o_item        (push_item),
        .o_weights     (weights)
    );

    lbc_fifo #(
        .WIDTH (ITEM_BITS),
        .DEPTH (QD)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_item),
        .i_pop   (pop),
        .o_dout  (q_item),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    lbc_back #(
        .KERNEL_H    (KERNEL_H),
        .KERNEL_W    (KERNEL_W),
        .IN_CH       (IN_CH),
        .OUT_CH      (OUT_CH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (pop),
        .i_weights  (weights),
        .o_busy     (back_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of line_buffered_conv2d: loads weights, walks several image
// settings and compares each result word against a predictor kept in this file.
// Depends on lbc_pkg and the line_buffered_conv2d RTL.
`timescale 1ns / 100ps

module tb;

    import lbc_pkg::*;

    localparam int KH        = 3;
    localparam int KW        = 3;
    localparam int ICH       = 3;
    localparam int OCH       = 4;
    localparam int LINE_W    = 1024;
    localparam int N_WEIGHTS = OCH * ICH * KH * KW;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [ROW_BITS-1:0]  row;
        logic [OCOL_BITS-1:0] col;
        logic [SUM_BITS-1:0]  sum [OCH];
    } t_conv_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [IN_TDATA_BITS-1:0]  s_data = '0;
    logic                      s_user = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    line_buffered_conv2d uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    // Predictor state: weights, line buffer, counters and registers.
    int                      weight_mem [N_WEIGHTS];
    int                      line_mem [KH*LINE_W][ICH];
    int                      row_cnt, col_cnt, row_ph, col_ph;
    logic [IMG_W_BITS-1:0]   img_w_reg;
    logic [IMG_H_BITS-1:0]   img_h_reg;
    logic [STRIDE_BITS-1:0]  stride_reg;

    t_conv_result pending_results [$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           stall_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int phase_step(int pos, int first, int ph, int s);
        if (pos < first) return 0;
        if (ph + 1 >= s) return 0;
        return ph + 1;
    endfunction

    // Updates the predictor for one accepted pixel and queues the window sum it causes.
    function automatic void convolve_pixel(logic [PFIELD_BITS*ICH-1:0] px);
        int w, h, s, col, r0, c0, bank, acc;
        t_conv_result res;
        w = clamp_int(int'(img_w_reg), 3, LINE_W);
        h = clamp_int(int'(img_h_reg), 3, 4096);
        s = clamp_int(int'(stride_reg), 1, 4);
        col = (col_cnt >= LINE_W) ? LINE_W - 1 : col_cnt;
        for (int ic = 0; ic < ICH; ic++) begin
            line_mem[(row_cnt % KH) * LINE_W + col][ic] =
                int'($signed(px[ic*PFIELD_BITS +: PFIELD_BITS]));
        end
        if (row_cnt >= KH - 1 && col >= KW - 1 && row_ph == 0 && col_ph == 0) begin
            r0 = row_cnt - (KH - 1);
            c0 = col - (KW - 1);
            res.row = ROW_BITS'(r0 / s);
            res.col = OCOL_BITS'(c0 / s);
            for (int oc = 0; oc < OCH; oc++) begin
                acc = 0;
                for (int ic = 0; ic < ICH; ic++)
                    for (int kr = 0; kr < KH; kr++)
                        for (int kc = 0; kc < KW; kc++) begin
                            bank = (r0 + kr) % KH;
                            acc += line_mem[bank * LINE_W + c0 + kc][ic] *
                                   weight_mem[((oc * ICH + ic) * KH + kr) * KW + kc];
                        end
                res.sum[oc] = acc;
            end
            pending_results.push_back(res);
        end
        // Raster counters and stride phases.
        if (col_cnt >= w - 1) begin
            col_cnt = 0;
            col_ph = 0;
            if (row_cnt >= h - 1) begin
                row_cnt = 0;
                row_ph = 0;
            end else begin
                row_ph = phase_step(row_cnt, KH - 1, row_ph, s);
                row_cnt++;
            end
        end else begin
            col_ph = phase_step(col_cnt, KW - 1, col_ph, s);
            col_cnt++;
        end
    endfunction

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_conv_result exp_res;
        t_conv_result got;
        if (i_rst_n && m_valid && m_ready) begin
            got.row = m_data[0 +: ROW_BITS];
            got.col = m_data[ROW_BITS +: OCOL_BITS];
            for (int oc = 0; oc < OCH; oc++)
                got.sum[oc] = m_data[ROW_BITS + OCOL_BITS + oc*SUM_BITS +: SUM_BITS];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word row %0d col %0d", got.row, got.col);
            end else begin
                exp_res = pending_results.pop_front();
                if (got.row !== exp_res.row || got.col !== exp_res.col) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("position mismatch: expected %0d/%0d got %0d/%0d",
                                 exp_res.row, exp_res.col, got.row, got.col);
                end
                for (int oc = 0; oc < OCH; oc++) begin
                    if (got.sum[oc] !== exp_res.sum[oc]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sum_ch%0d mismatch at %0d/%0d: expected %0d got %0d",
                                     oc, exp_res.row, exp_res.col,
                                     $signed(exp_res.sum[oc]), $signed(got.sum[oc]));
                    end
                end
            end
        end
    end

    // Sends one stream word; the predictor is updated when it is accepted.
    task automatic send_word(t_cmd cmd, logic [WIDX_BITS-1:0] idx, logic [WVAL_BITS-1:0] wval,
                             logic [PFIELD_BITS*ICH-1:0] px);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {1'b0, px, wval, idx};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (cmd == CMD_WEIGHT) begin
            if (int'(idx) < N_WEIGHTS) weight_mem[idx] = int'($signed(wval));
        end else begin
            convolve_pixel(px);
        end
    endtask

    task automatic send_pixel();
        send_word(CMD_PIXEL, WIDX_BITS'($urandom), WVAL_BITS'($urandom), 24'($urandom));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg addr, logic [CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (addr)
            CFG_IMG_W:  img_w_reg  = value[IMG_W_BITS-1:0];
            CFG_IMG_H:  img_h_reg  = value[IMG_H_BITS-1:0];
            CFG_STRIDE: stride_reg = value[STRIDE_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Brings the raster back to the start of a frame by shrinking it, then applies
    // a new setting; new frames never read columns that were not written.
    task automatic apply_setting(int w, int h, int s);
        wait_for_results();
        if (row_cnt != 0 || col_cnt != 0) begin
            write_reg(CFG_IMG_W, 13'd3);
            write_reg(CFG_IMG_H, 13'd3);
            while (row_cnt != 0 || col_cnt != 0) send_pixel();
            wait_for_results();
        end
        write_reg(CFG_IMG_W, CFG_DATA_BITS'(w));
        write_reg(CFG_IMG_H, CFG_DATA_BITS'(h));
        write_reg(CFG_STRIDE, CFG_DATA_BITS'(s));
    endtask

    // Every weight is loaded before any pixel; out-of-range indexes must be ignored.
    task automatic test_weight_load();
        for (int i = 0; i < N_WEIGHTS; i++) begin
            case (i % 4)
                0: send_word(CMD_WEIGHT, WIDX_BITS'(i), 8'h80, 24'($urandom));
                1: send_word(CMD_WEIGHT, WIDX_BITS'(i), 8'h7f, 24'($urandom));
                default: send_word(CMD_WEIGHT, WIDX_BITS'(i), WVAL_BITS'($urandom),
                                   24'($urandom));
            endcase
        end
        send_word(CMD_WEIGHT, 7'd108, 8'h55, '0);
        send_word(CMD_WEIGHT, 7'd127, 8'haa, '1);
    endtask

    // Smallest frame with extreme samples: one window of most negative, then most positive.
    task automatic test_extreme_window();
        apply_setting(3, 3, 1);
        for (int i = 0; i < 9; i++) send_word(CMD_PIXEL, '0, '0, {ICH{8'h80}});
        for (int i = 0; i < 9; i++) send_word(CMD_PIXEL, '1, '1, {ICH{8'h7f}});
        for (int i = 0; i < 4; i++) send_word(CMD_PIXEL, '0, '0, '0);
        wait_for_results();
    endtask

    // Random pixels under one setting, with weight rewrites mixed in and one full drain.
    task automatic test_random_frames(int w, int h, int s, int n_items);
        logic [WIDX_BITS-1:0] idx;
        apply_setting(w, h, s);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) wait_for_results();
            if ($urandom_range(0, 99) < 4) begin
                idx = ($urandom_range(0, 9) == 0) ? WIDX_BITS'($urandom_range(108, 127))
                                                  : WIDX_BITS'($urandom_range(0, 107));
                send_word(CMD_WEIGHT, idx, WVAL_BITS'($urandom), 24'($urandom));
            end else begin
                send_pixel();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < N_WEIGHTS; i++) weight_mem[i] = 0;
        row_cnt = 0;
        col_cnt = 0;
        row_ph = 0;
        col_ph = 0;
        img_w_reg  = IMG_W_RESET;
        img_h_reg  = IMG_H_RESET;
        stride_reg = STRIDE_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 23;
        recv_idle_pct = 72;
        test_weight_load();
        test_extreme_window();
        test_random_frames(0, 0, 0, 110);
        test_random_frames(5, 4, 2, 110);
        test_random_frames(7, 9, 3, 110);

        // The other way round.
        send_idle_pct = 72;
        recv_idle_pct = 23;
        test_random_frames(16, 6, 4, 110);
        test_random_frames(10, 5, 7, 110);
        test_random_frames(4, 8191, 5, 80);

        // No idling; the widest line runs here.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(2047, 3, 1, 300);
        test_random_frames(12, 7, 2, 110);
        test_random_frames(1024, 4096, 3, 40);
        test_random_frames(3, 3, 1, 60);

        wait_for_results();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
